// File: hdl/ggc_pkg.sv
// Shared widths, types and helpers for the greedy graph colouring block.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package ggc_pkg;

    localparam int ROW_W    = 64;
    localparam int VIDX_W   = 6;
    localparam int COLOUR_W = 6;
    localparam int COUNT_W  = 7;
    localparam int GROUP_W  = 8;
    localparam int GROUPS   = ROW_W / GROUP_W;
    localparam int GSEL_W   = 3;

    localparam int MAX_VERTICES_DEF = 64;
    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

    typedef logic [ROW_W-1:0]    t_row;
    typedef logic [VIDX_W-1:0]   t_vidx;
    typedef logic [COLOUR_W-1:0] t_colour;
    typedef logic [COUNT_W-1:0]  t_count;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic find;
        logic commit;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic can_commit;
    } t_ctl_sts;

    // Position of the lowest clear bit of a byte; 7 when all are set.
    function automatic logic [GSEL_W-1:0] first_zero8(input logic [GROUP_W-1:0] v);
        logic [GSEL_W-1:0] r;
        r = GSEL_W'(GROUP_W - 1);
        for (int b = GROUP_W - 1; b >= 0; b--) begin
            if (!v[b]) begin
                r = GSEL_W'(b);
            end
        end
        return r;
    endfunction

endpackage

// File: hdl/ggc_ifs.sv
// Valid/ready channel interfaces for the adjacency rows and the colouring results.
// Depends on ggc_pkg for the payload types.
`timescale 1ns / 1ps

interface ggc_in_if;
    logic            valid;
    logic            ready;
    ggc_pkg::t_row   neighbour_row;

    modport source (output valid, output neighbour_row, input ready);
    modport sink   (input valid, input neighbour_row, output ready);
endinterface

interface ggc_out_if;
    logic              valid;
    logic              ready;
    ggc_pkg::t_vidx    vertex_index;
    ggc_pkg::t_colour  assigned_colour;
    ggc_pkg::t_count   colours_used;
    logic              last_vertex;

    modport source (output valid, output vertex_index, output assigned_colour,
                    output colours_used, output last_vertex, input ready);
    modport sink   (input valid, input vertex_index, input assigned_colour,
                    input colours_used, input last_vertex, output ready);
endinterface

// File: hdl/ggc_ctrl.sv
// Sequencing state machine of the colouring block: accept, scan, search, commit.
// Depends on ggc_pkg for the command and status structs.
`timescale 1ns / 1ps

module ggc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ggc_pkg::t_ctl_sts i_sts,
    output ggc_pkg::t_ctl_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIND = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                o_cmd.find = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                // Wait here only while an earlier result still sits unread.
                if (i_sts.can_commit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/ggc_datapath.sv
// Datapath of the colouring block: colour memory, neighbour scan, free-colour search,
// per-graph counters, configuration register and output register. Depends on ggc_pkg.
`timescale 1ns / 1ps

module ggc_datapath #(
    parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ggc_pkg::t_ctl_cmd     i_cmd,
    output ggc_pkg::t_ctl_sts     o_sts,
    input  logic                  i_cfg_wr_en,
    input  ggc_pkg::t_count       i_cfg_wr_data,
    input  ggc_pkg::t_row         i_row,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output ggc_pkg::t_vidx        o_vertex_index,
    output ggc_pkg::t_colour      o_assigned_colour,
    output ggc_pkg::t_count       o_colours_used,
    output logic                  o_last_vertex
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam ggc_pkg::t_count MAX_N = ggc_pkg::t_count'(MAX_VERTICES);

    ggc_pkg::t_colour r_store [MAX_VERTICES];

    ggc_pkg::t_count   r_vertex_count;
    ggc_pkg::t_vidx    r_vertex_counter;
    ggc_pkg::t_count   r_colour_total;
    ggc_pkg::t_row     r_row;
    ggc_pkg::t_vidx    r_k;
    ggc_pkg::t_row     r_taken;
    logic              r_hit;
    ggc_pkg::t_colour  r_rd_data;
    logic [ggc_pkg::GROUPS-1:0] r_grp_full;
    logic [ggc_pkg::GSEL_W-1:0] r_grp_first [ggc_pkg::GROUPS];
    logic              r_out_valid;
    ggc_pkg::t_vidx    r_out_index;
    ggc_pkg::t_colour  r_out_colour;
    ggc_pkg::t_count   r_out_used;
    logic              r_out_last;

    logic              scan_done;
    logic              issue;
    ggc_pkg::t_colour  colour;
    ggc_pkg::t_count   colour_plus1;
    ggc_pkg::t_count   n_colour_total;
    ggc_pkg::t_count   eff_count;
    logic              last;

    assign scan_done = (r_k == r_vertex_counter);
    assign issue     = i_cmd.scan && !scan_done;

    assign o_sts.scan_done  = scan_done;
    assign o_sts.can_commit = !r_out_valid || i_out_ready;

    // Lowest free colour: first group that is not full, then its lowest clear bit.
    always_comb begin
        colour = ggc_pkg::t_colour'(ggc_pkg::ROW_W - 1);
        for (int g = ggc_pkg::GROUPS - 1; g >= 0; g--) begin
            if (!r_grp_full[g]) begin
                colour = {ggc_pkg::GSEL_W'(g), r_grp_first[g]};
            end
        end
    end

    always_comb begin
        colour_plus1   = {1'b0, colour} + ggc_pkg::t_count'(1);
        n_colour_total = (colour_plus1 > r_colour_total) ? colour_plus1 : r_colour_total;
        if (r_vertex_count == '0) begin
            eff_count = ggc_pkg::t_count'(1);
        end else if (r_vertex_count > MAX_N) begin
            eff_count = MAX_N;
        end else begin
            eff_count = r_vertex_count;
        end
        last = (({1'b0, r_vertex_counter} + ggc_pkg::t_count'(1)) >= eff_count);
    end

    // Colour memory: one read per scan cycle, one write per committed vertex.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_store[r_k[AW-1:0]];
        end
        if (i_cmd.commit) begin
            r_store[r_vertex_counter[AW-1:0]] <= colour;
        end
    end

    // Scan of the earlier vertices, one per cycle, with the read data used in the cycle after its read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row   <= i_row;
            r_k     <= '0;
            r_taken <= '0;
        end else begin
            if (issue) begin
                r_row <= r_row >> 1;
                r_k   <= r_k + ggc_pkg::t_vidx'(1);
            end
            if (r_hit) begin
                r_taken <= r_taken | (ggc_pkg::t_row'(1) << r_rd_data);
            end
        end
        if (i_cmd.find) begin
            for (int g = 0; g < ggc_pkg::GROUPS; g++) begin
                r_grp_full[g]  <= &r_taken[g*ggc_pkg::GROUP_W +: ggc_pkg::GROUP_W];
                r_grp_first[g] <= ggc_pkg::first_zero8(
                    r_taken[g*ggc_pkg::GROUP_W +: ggc_pkg::GROUP_W]);
            end
        end
        if (i_cmd.commit) begin
            r_out_index  <= r_vertex_counter;
            r_out_colour <= colour;
            r_out_used   <= n_colour_total;
            r_out_last   <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count   <= ggc_pkg::VERTEX_COUNT_RST;
            r_vertex_counter <= '0;
            r_colour_total   <= '0;
            r_hit            <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vertex_count <= i_cfg_wr_data;
            end
            r_hit <= issue && r_row[0];
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (last) begin
                    r_vertex_counter <= '0;
                    r_colour_total   <= '0;
                end else begin
                    r_vertex_counter <= r_vertex_counter + ggc_pkg::t_vidx'(1);
                    r_colour_total   <= n_colour_total;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_vertex_index    = r_out_index;
    assign o_assigned_colour = r_out_colour;
    assign o_colours_used    = r_out_used;
    assign o_last_vertex     = r_out_last;

endmodule

// File: hdl/greedy_graph_colouring.sv
// Top level of the first-fit greedy vertex colouring block.
// Depends on ggc_pkg, ggc_ifs (channel interfaces), ggc_ctrl and ggc_datapath.
//
// Usage:
//   Vertices of a graph arrive in index order on i_in, one adjacency row per
//   transaction; bit k of neighbour_row marks an edge to vertex k. Only bits
//   below the current vertex index are looked at. Each vertex yields one
//   transaction on o_out with its index, its colour, the colour count of the
//   graph so far and a last flag on the final vertex of the graph.
//   The vertex count is written through i_cfg_wr_en / i_cfg_wr_data while the
//   block is idle; 0 acts as 1 and values above MAX_VERTICES act as MAX_VERTICES.
//   Sequence: vertex i is scanned against its i predecessors, one colour memory
//   read per cycle; then the free colour is searched and the result committed,
//   and the next row is taken once that result is valid.
//   The result sits in an output register; a new row is accepted while it waits,
//   and the block only holds before its own commit if that register is still full.
//   Reset restores a vertex count of 64 and starts a new graph at vertex 0; the
//   colour memory needs no clearing since only vertices of the current graph are read.
`timescale 1ns / 1ps

module greedy_graph_colouring #(
    parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  ggc_pkg::t_count  i_cfg_wr_data,
    ggc_in_if.sink           i_in,
    ggc_out_if.source        o_out
);

    ggc_pkg::t_ctl_cmd cmd;
    ggc_pkg::t_ctl_sts sts;
    logic              in_ready;

    ggc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ggc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_row             (i_in.neighbour_row),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_vertex_index    (o_out.vertex_index),
        .o_assigned_colour (o_out.assigned_colour),
        .o_colours_used    (o_out.colours_used),
        .o_last_vertex     (o_out.last_vertex)
    );

    assign i_in.ready = in_ready;

endmodule

// File: hdl/ggc_checker.sv
// Port-level checks of the greedy graph colouring block, bound to its top level.
// Depends on ggc_pkg for the field types.
`timescale 1ns / 1ps

module ggc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input ggc_pkg::t_vidx   i_vertex_index,
    input ggc_pkg::t_colour i_assigned_colour,
    input ggc_pkg::t_count  i_colours_used,
    input logic             i_last_vertex
);

    // One vertex is in work at a time, so a transaction closes the input for a while.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted on two consecutive cycles");

    a_colour_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ({1'b0, i_assigned_colour} < i_colours_used))
        else $error("colour not covered by the colour count");

    a_colour_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_assigned_colour <= i_vertex_index))
        else $error("colour exceeds the number of earlier vertices");

    a_first_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_vertex_index == '0)) |->
            (i_assigned_colour == '0) && (i_colours_used == ggc_pkg::t_count'(1)))
        else $error("first vertex of a graph not given colour zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_vertex_index) && $stable(i_assigned_colour)
             && $stable(i_colours_used) && $stable(i_last_vertex)))
        else $error("stalled result changed");

endmodule

bind greedy_graph_colouring ggc_checker u_ggc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_vertex_index    (o_out.vertex_index),
    .i_assigned_colour (o_out.assigned_colour),
    .i_colours_used    (o_out.colours_used),
    .i_last_vertex     (o_out.last_vertex)
);
